// File: src/flame_grid_heat_step_unit_assert.svh
// Assertion macros shared by the flame grid heat step modules.
`ifndef FLAME_GRID_HEAT_STEP_UNIT_ASSERT_SVH
`define FLAME_GRID_HEAT_STEP_UNIT_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define FGHS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define FGHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// At most one bit of the vector is set.
`define FGHS_ASSERT_ONEHOT0(lbl, vec, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot0(vec)) \
        else $error(msg);

`endif

// File: src/fghs_pkg.sv
// Shared constants, codes and types of the flame grid heat step unit.
package fghs_pkg;

    localparam int DEF_GRID_WIDTH  = 20;
    localparam int DEF_GRID_HEIGHT = 17;

    localparam int TEMP_W   = 16;
    localparam int WEIGHT_W = 8;
    localparam int ACTION_W = 2;
    localparam int COORD_W  = 5;
    localparam int FUEL_W   = 8;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [ACTION_W-1:0] ACT_FUEL = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GEN  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

    localparam logic [1:0] REG_LOSS   = 2'd0;
    localparam logic [1:0] REG_KEEP   = 2'd1;
    localparam logic [1:0] REG_RISE   = 2'd2;
    localparam logic [1:0] REG_SPREAD = 2'd3;

    localparam logic [WEIGHT_W-1:0] RST_LOSS   = 8'd230;
    localparam logic [WEIGHT_W-1:0] RST_KEEP   = 8'd51;
    localparam logic [WEIGHT_W-1:0] RST_RISE   = 8'd154;
    localparam logic [WEIGHT_W-1:0] RST_SPREAD = 8'd26;

    typedef logic [TEMP_W-1:0]   t_temp;
    typedef logic [WEIGHT_W-1:0] t_weight;

    typedef struct packed {
        t_weight loss;
        t_weight keep;
        t_weight rise;
        t_weight spread;
    } t_weights;

    typedef struct packed {
        logic clr_we;
        logic load_item;
        logic item_row_en;
        logic sel_item;
        logic fuel_we;
        logic gen_step;
        logic gen_out;
        logic keep_en;
        logic feed_en;
        logic res_load;
        logic res_read;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic col_ok;
        logic row_ok;
        logic pipe_busy;
    } t_dp_stat;

endpackage

// File: src/fghs_ctrl.sv
// Controller state machine: clear sweep, item dispatch and generation sequencing.
`include "flame_grid_heat_step_unit_assert.svh"

module fghs_ctrl
    import fghs_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT,
    localparam int AW    = $clog2(DEPTH),
    localparam int JW    = $clog2(GRID_WIDTH + 2),
    localparam int YW    = $clog2(GRID_HEIGHT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACTION_W-1:0] i_action,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  t_dp_stat            i_stat,
    output t_dp_cmd             o_cmd,
    output logic [AW-1:0]       o_addr_a,
    output logic [AW-1:0]       o_addr_b
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ACCESS = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_GEN    = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [JW-1:0] r_j, n_j;
    logic [YW-1:0] r_y, n_y;
    logic [AW-1:0] r_base_cur, n_base_cur;
    logic [AW-1:0] r_base_below, n_base_below;
    logic          r_is_fuel, n_is_fuel;
    logic          r_is_read, n_is_read;
    logic          r_out_valid, n_out_valid;

    logic          j_last;
    logic          gen_out;
    logic [AW-1:0] idx_a;
    logic [AW-1:0] x_off;

    assign j_last  = (r_j == JW'(GRID_WIDTH + 1));
    assign gen_out = (r_j >= JW'(2));

    // The below-row read walks the wrapped sequence W-1, 0 .. W-1, 0 so that the
    // three-tap window holds left, center and right neighbors of each output cell.
    always_comb begin
        if (r_j == '0) begin
            idx_a = AW'(GRID_WIDTH - 1);
        end else if (j_last) begin
            idx_a = '0;
        end else begin
            idx_a = AW'(r_j) - AW'(1);
        end
        x_off = gen_out ? (AW'(r_j) - AW'(2)) : '0;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_j          = r_j;
        n_y          = r_y;
        n_base_cur   = r_base_cur;
        n_base_below = r_base_below;
        n_is_fuel    = r_is_fuel;
        n_is_read    = r_is_read;
        n_out_valid  = r_out_valid;
        o_cmd        = '0;
        o_addr_a     = r_base_below + idx_a;
        o_addr_b     = r_clr_addr;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                n_clr_addr   = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_action)
                        ACT_FUEL: begin
                            if (i_stat.col_ok) begin
                                o_cmd.load_item = 1'b1;
                                n_is_fuel       = 1'b1;
                                n_is_read       = 1'b0;
                                n_state         = S_ACCESS;
                            end else begin
                                o_cmd.res_load = 1'b1;
                                n_state        = S_DONE;
                            end
                        end
                        ACT_READ: begin
                            if (i_stat.col_ok && i_stat.row_ok) begin
                                o_cmd.load_item   = 1'b1;
                                o_cmd.item_row_en = 1'b1;
                                n_is_fuel         = 1'b0;
                                n_is_read         = 1'b1;
                                n_state           = S_ACCESS;
                            end else begin
                                o_cmd.res_load = 1'b1;
                                n_state        = S_DONE;
                            end
                        end
                        ACT_GEN: begin
                            n_j          = '0;
                            n_y          = YW'(GRID_HEIGHT - 1);
                            n_base_cur   = AW'((GRID_HEIGHT - 1) * GRID_WIDTH);
                            n_base_below = AW'((GRID_HEIGHT - 2) * GRID_WIDTH);
                            n_state      = S_GEN;
                        end
                        default: begin
                            o_cmd.res_load = 1'b1;
                            n_state        = S_DONE;
                        end
                    endcase
                end
            end
            S_ACCESS: begin
                o_cmd.sel_item = 1'b1;
                n_state        = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.fuel_we  = r_is_fuel;
                o_cmd.res_load = 1'b1;
                o_cmd.res_read = r_is_read;
                n_state        = S_DONE;
            end
            S_GEN: begin
                o_cmd.gen_step = 1'b1;
                o_cmd.gen_out  = gen_out;
                // The old top row gets no kept share; the bottom row gets no feed.
                o_cmd.keep_en  = (r_y != YW'(GRID_HEIGHT - 1));
                o_cmd.feed_en  = (r_y != '0);
                o_addr_b       = r_base_cur + x_off;
                if (j_last) begin
                    n_j = '0;
                    if (r_y == '0) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_y          = r_y - YW'(1);
                        n_base_cur   = r_base_below;
                        n_base_below = (r_y == YW'(1)) ? '0 : (r_base_below - AW'(GRID_WIDTH));
                    end
                end else begin
                    n_j = r_j + JW'(1);
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j          <= n_j;
        r_y          <= n_y;
        r_base_cur   <= n_base_cur;
        r_base_below <= n_base_below;
        r_is_fuel    <= n_is_fuel;
        r_is_read    <= n_is_read;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `FGHS_ASSERT_NEXT(a_gen_exit, (r_state == S_GEN), (r_state == S_GEN || r_state == S_DRAIN), "generation left without draining")
    `FGHS_ASSERT_IMPLY(a_done_pipe_idle, (r_state == S_DONE), (!i_stat.pipe_busy), "result staged while generation writes pending")
    `FGHS_ASSERT_IMPLY(a_out_from_done, ($rose(r_out_valid)), ($past(r_state == S_DONE)), "result presented outside the done state")

endmodule

// File: src/fghs_dp.sv
// Datapath: heat grid memory, item address, generation pipeline and result registers.
`include "flame_grid_heat_step_unit_assert.svh"

module fghs_dp
    import fghs_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [AW-1:0]      i_addr_a,
    input  logic [AW-1:0]      i_addr_b,
    input  t_weights           i_weights,
    input  logic [COORD_W-1:0] i_column,
    input  logic [COORD_W-1:0] i_row,
    input  logic [FUEL_W-1:0]  i_fuel_amount,
    output t_temp              o_temperature,
    output logic               o_is_read_data
);

    localparam int SUM_W  = TEMP_W + 2;
    localparam int PROD_W = TEMP_W + WEIGHT_W;

    function automatic t_temp scale(input t_temp v, input t_weight w);
        logic [PROD_W-1:0] p;
        p = {{WEIGHT_W{1'b0}}, v} * {{TEMP_W{1'b0}}, w};
        return p[PROD_W-1:WEIGHT_W];
    endfunction

    t_temp             r_mem [DEPTH];
    t_temp             r_rd_a, r_rd_b;
    logic [AW-1:0]     r_item_addr;
    logic [FUEL_W-1:0] r_fuel;

    logic [AW-1:0]     rd_addr_b;
    logic [AW-1:0]     wr_addr;
    t_temp             wr_data;
    logic              wr_en;
    logic [2:0]        wr_sel;
    logic [TEMP_W:0]   fuel_sum;
    t_temp             fuel_sat;

    // Generation pipeline.
    logic          r_p1_step, r_p1_wv, r_p1_keep, r_p1_feed;
    logic [AW-1:0] r_p1_addr;
    logic          r_p2_wv, r_p2_keep, r_p2_feed;
    logic [AW-1:0] r_p2_addr;
    t_temp         r_win_l, r_win_c, r_win_r, r_cd;
    logic          r_p3_wv;
    logic [AW-1:0] r_p3_addr;
    t_temp         r_t_keep, r_t_rise, r_t_sl, r_t_sr;
    logic          r_p4_wv;
    logic [AW-1:0] r_p4_addr;
    t_temp         r_wr_gen;
    logic [SUM_W-1:0] sum4;

    t_temp r_res_temp, r_out_temp;
    logic  r_res_flag, r_out_flag;

    assign o_stat.col_ok    = (32'(i_column) < 32'(GRID_WIDTH));
    assign o_stat.row_ok    = (32'(i_row) < 32'(GRID_HEIGHT));
    assign o_stat.pipe_busy = r_p1_step | r_p2_wv | r_p3_wv | r_p4_wv;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_fuel <= i_fuel_amount;
            if (i_cmd.item_row_en) begin
                r_item_addr <= AW'(32'(i_row) * 32'(GRID_WIDTH) + 32'(i_column));
            end else begin
                r_item_addr <= AW'(i_column);
            end
        end
    end

    assign rd_addr_b = i_cmd.sel_item ? r_item_addr : i_addr_b;
    assign fuel_sum  = {1'b0, r_rd_b} + {1'b0, r_fuel, {(TEMP_W - FUEL_W){1'b0}}};
    assign fuel_sat  = fuel_sum[TEMP_W] ? '1 : fuel_sum[TEMP_W-1:0];

    always_comb begin
        wr_sel  = {i_cmd.clr_we, i_cmd.fuel_we, r_p4_wv};
        wr_en   = |wr_sel;
        wr_addr = r_p4_addr;
        wr_data = r_wr_gen;
        if (i_cmd.clr_we) begin
            wr_addr = i_addr_b;
            wr_data = '0;
        end else if (i_cmd.fuel_we) begin
            wr_addr = r_item_addr;
            wr_data = fuel_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[i_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_step <= 1'b0;
            r_p1_wv   <= 1'b0;
            r_p2_wv   <= 1'b0;
            r_p3_wv   <= 1'b0;
            r_p4_wv   <= 1'b0;
        end else begin
            r_p1_step <= i_cmd.gen_step;
            r_p1_wv   <= i_cmd.gen_step & i_cmd.gen_out;
            r_p2_wv   <= r_p1_wv;
            r_p3_wv   <= r_p2_wv;
            r_p4_wv   <= r_p3_wv;
        end
    end

    assign sum4 = SUM_W'(r_t_keep) + SUM_W'(r_t_rise) + SUM_W'(r_t_sl) + SUM_W'(r_t_sr);

    always_ff @(posedge i_clk) begin
        r_p1_keep <= i_cmd.keep_en;
        r_p1_feed <= i_cmd.feed_en;
        r_p1_addr <= i_addr_b;

        // Decay stage: the below-row value enters the window, the own cell decays too.
        if (r_p1_step) begin
            r_win_l <= r_win_c;
            r_win_c <= r_win_r;
            r_win_r <= scale(r_rd_a, i_weights.loss);
        end
        r_cd      <= scale(r_rd_b, i_weights.loss);
        r_p2_keep <= r_p1_keep;
        r_p2_feed <= r_p1_feed;
        r_p2_addr <= r_p1_addr;

        // Share stage.
        r_t_keep  <= r_p2_keep ? scale(r_cd, i_weights.keep) : '0;
        r_t_rise  <= r_p2_feed ? scale(r_win_c, i_weights.rise) : '0;
        r_t_sl    <= r_p2_feed ? scale(r_win_l, i_weights.spread) : '0;
        r_t_sr    <= r_p2_feed ? scale(r_win_r, i_weights.spread) : '0;
        r_p3_addr <= r_p2_addr;

        // Saturating sum stage.
        r_wr_gen  <= (|sum4[SUM_W-1:TEMP_W]) ? '1 : sum4[TEMP_W-1:0];
        r_p4_addr <= r_p3_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_temp <= i_cmd.res_read ? r_rd_b : '0;
            r_res_flag <= i_cmd.res_read;
        end
        if (i_cmd.out_load) begin
            r_out_temp <= r_res_temp;
            r_out_flag <= r_res_flag;
        end
    end

    assign o_temperature  = r_out_temp;
    assign o_is_read_data = r_out_flag;

    `FGHS_ASSERT_ONEHOT0(a_one_writer, wr_sel, "more than one source writes the grid")
    `FGHS_ASSERT_IMPLY(a_fuel_after_read, (i_cmd.fuel_we), ($past(i_cmd.sel_item)), "fuel write without a prior cell read")

endmodule

// File: src/flame_grid_heat_step_unit.sv
// Top level of the flame grid heat step unit: register port, controller and datapath.
//
// The block keeps a GRID_WIDTH by GRID_HEIGHT grid of 8.8 cell temperatures in
// one memory with two read ports and one write port.
// Input channel (i_in_valid / o_in_stall): one item per handshake. Fuel adds heat
// to a bottom-row cell, a generation item steps the whole grid, a read item
// returns one cell. Output channel (o_out_valid / i_out_stall): one result per item.
// Fuel and read items pass through an access state and an update state before their
// result is staged. An unused action or an out-of-range coordinate skips the memory.
// In a generation the pipeline handles one cell a cycle, each row costs two extra
// reads for the wrapped neighbor window, then the pipeline writes drain, and the
// result is staged and the block returns to idle.
// After reset a clearing pass writes zero to all GRID_WIDTH*GRID_HEIGHT cells,
// one per cycle, while o_in_stall stays high; the register port works throughout.
// A stalled result stays in the output register; the next item is still accepted
// and processed, and its result waits until the register is taken.
// Registers are to be written over the APB-style port only while the block is idle; the block does not enforce this.
module flame_grid_heat_step_unit
    import fghs_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [COORD_W-1:0]  i_column,
    input  logic [COORD_W-1:0]  i_row,
    input  logic [FUEL_W-1:0]   i_fuel_amount,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [TEMP_W-1:0]   o_temperature,
    output logic                o_is_read_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);

    t_weights      r_weights;
    logic          cfg_wr;
    t_dp_cmd       dp_cmd;
    t_dp_stat      dp_stat;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights.loss   <= RST_LOSS;
            r_weights.keep   <= RST_KEEP;
            r_weights.rise   <= RST_RISE;
            r_weights.spread <= RST_SPREAD;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LOSS:   r_weights.loss   <= pwdata[WEIGHT_W-1:0];
                REG_KEEP:   r_weights.keep   <= pwdata[WEIGHT_W-1:0];
                REG_RISE:   r_weights.rise   <= pwdata[WEIGHT_W-1:0];
                REG_SPREAD: r_weights.spread <= pwdata[WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LOSS:   prdata = APB_DW'(r_weights.loss);
            REG_KEEP:   prdata = APB_DW'(r_weights.keep);
            REG_RISE:   prdata = APB_DW'(r_weights.rise);
            REG_SPREAD: prdata = APB_DW'(r_weights.spread);
            default:    prdata = '0;
        endcase
    end

    fghs_ctrl #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd),
        .o_addr_a    (addr_a),
        .o_addr_b    (addr_b)
    );

    fghs_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_addr_a       (addr_a),
        .i_addr_b       (addr_b),
        .i_weights      (r_weights),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_fuel_amount  (i_fuel_amount),
        .o_temperature  (o_temperature),
        .o_is_read_data (o_is_read_data)
    );

endmodule

// File: dv/tb.sv
// Self-checking testbench for the flame grid heat step unit: predicts every result and compares.
module tb
    import fghs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W      = DEF_GRID_WIDTH;
    localparam int GRID_H      = DEF_GRID_HEIGHT;
    localparam int GRID_CELLS  = GRID_W * GRID_H;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_ITEMS = 100;

    // The package names only the three used actions.
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        t_temp temperature;
        logic  is_read_data;
    } t_heat_reading;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [ACTION_W-1:0] i_action = '0;
    logic [COORD_W-1:0]  i_column = '0;
    logic [COORD_W-1:0]  i_row = '0;
    logic [FUEL_W-1:0]   i_fuel_amount = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [TEMP_W-1:0]   o_temperature;
    logic                o_is_read_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    flame_grid_heat_step_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_fuel_amount  (i_fuel_amount),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_temperature  (o_temperature),
        .o_is_read_data (o_is_read_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Predicted state of the block.
    t_temp   heat_cells [GRID_CELLS];
    t_weight loss_w   = RST_LOSS;
    t_weight keep_w   = RST_KEEP;
    t_weight rise_w   = RST_RISE;
    t_weight spread_w = RST_SPREAD;

    t_heat_reading pending_readings [$];
    int            errors = 0;
    bit            no_idle = 1'b0;
    int            stall_left = 0;
    int            idle_cycles = 0;

    function automatic t_temp weigh(input t_temp v, input t_weight w);
        logic [23:0] p;
        p = {8'h00, v} * {16'h0000, w};
        return p[23:8];
    endfunction

    function automatic t_temp sat_sum(input t_temp a, input t_temp b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // Rows are rebuilt from the top down so the old rows y and y-1 are still intact.
    function automatic void run_generation();
        t_temp decayed [GRID_W];
        t_temp acc;
        int    left;
        int    right;
        for (int y = GRID_H - 1; y >= 1; y--) begin
            for (int x = 0; x < GRID_W; x++)
                decayed[x] = weigh(heat_cells[(y - 1) * GRID_W + x], loss_w);
            for (int x = 0; x < GRID_W; x++) begin
                acc   = '0;
                left  = (x + GRID_W - 1) % GRID_W;
                right = (x + 1) % GRID_W;
                if (y < GRID_H - 1)
                    acc = sat_sum(acc, weigh(weigh(heat_cells[y * GRID_W + x], loss_w), keep_w));
                acc = sat_sum(acc, weigh(decayed[x], rise_w));
                acc = sat_sum(acc, weigh(decayed[left], spread_w));
                acc = sat_sum(acc, weigh(decayed[right], spread_w));
                heat_cells[y * GRID_W + x] = acc;
            end
        end
        for (int x = 0; x < GRID_W; x++)
            heat_cells[x] = weigh(weigh(heat_cells[x], loss_w), keep_w);
    endfunction

    function automatic t_heat_reading predict_item(input logic [ACTION_W-1:0] act,
                                                   input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row,
                                                   input logic [FUEL_W-1:0] fuel);
        t_heat_reading r;
        r = '0;
        case (act)
            ACT_FUEL: begin
                if (col < GRID_W)
                    heat_cells[col] = sat_sum(heat_cells[col], {fuel, 8'h00});
            end
            ACT_GEN: begin
                run_generation();
            end
            ACT_READ: begin
                if (col < GRID_W && row < GRID_H) begin
                    r.temperature  = heat_cells[row * GRID_W + col];
                    r.is_read_data = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [COORD_W-1:0] col,
                             input logic [COORD_W-1:0] row, input logic [FUEL_W-1:0] fuel);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_column      <= col;
        i_row         <= row;
        i_fuel_amount <= fuel;
        do @(posedge i_clk); while (o_in_stall);
        pending_readings.push_back(predict_item(act, col, row, fuel));
    endtask

    // Waits until every predicted result has arrived and the block accepts again.
    task automatic settle_block();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0 || o_in_stall);
    endtask

    task automatic write_weight(input logic [1:0] idx, input t_weight val);
        logic [APB_DW-1:0] data;
        data       = $urandom;
        data[7:0]  = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_LOSS:   loss_w   = val;
            REG_KEEP:   keep_w   = val;
            REG_RISE:   rise_w   = val;
            REG_SPREAD: spread_w = val;
            default: begin
            end
        endcase
    endtask

    task automatic set_weights(input t_weight loss, input t_weight keep,
                               input t_weight rise, input t_weight spread);
        settle_block();
        write_weight(REG_LOSS, loss);
        write_weight(REG_KEEP, keep);
        write_weight(REG_RISE, rise);
        write_weight(REG_SPREAD, spread);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_weight draw_weight();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return 8'd0;
        else if (pick == 1)
            return 8'd255;
        return t_weight'($urandom_range(0, 255));
    endfunction

    task automatic test_directed_cells();
        send_item(ACT_READ, 5'd0, 5'd0, 8'd0);
        send_item(ACT_FUEL, 5'd0, 5'd31, 8'd255);
        send_item(ACT_FUEL, 5'd0, 5'd0, 8'd255);
        send_item(ACT_READ, 5'd0, 5'd0, 8'd255);
        send_item(ACT_FUEL, 5'd19, 5'd0, 8'd1);
        send_item(ACT_FUEL, 5'd5, 5'd0, 8'd0);
        send_item(ACT_FUEL, 5'd20, 5'd0, 8'd255);
        send_item(ACT_FUEL, 5'd31, 5'd31, 8'd128);
        send_item(ACT_READ, 5'd19, 5'd0, 8'd0);
        send_item(ACT_READ, 5'd20, 5'd0, 8'd0);
        send_item(ACT_READ, 5'd31, 5'd31, 8'd0);
        send_item(ACT_READ, 5'd0, 5'd17, 8'd0);
        send_item(ACT_READ, 5'd19, 5'd16, 8'd0);
        send_item(ACT_NONE, 5'd3, 5'd0, 8'd255);
        send_item(ACT_NONE, 5'd31, 5'd31, 8'd0);
        send_item(ACT_GEN, 5'd0, 5'd0, 8'd0);
        send_item(ACT_READ, 5'd0, 5'd1, 8'd0);
        send_item(ACT_READ, 5'd1, 5'd1, 8'd0);
        send_item(ACT_READ, 5'd19, 5'd1, 8'd0);
        send_item(ACT_READ, 5'd0, 5'd0, 8'd0);
        send_item(ACT_GEN, 5'd31, 5'd31, 8'd255);
        send_item(ACT_READ, 5'd0, 5'd2, 8'd0);
    endtask

    // Full weights exercise the saturating sums; zero weights wipe the grid.
    task automatic test_weight_extremes();
        set_weights(8'd255, 8'd255, 8'd255, 8'd255);
        for (int c = 0; c < GRID_W; c += 6) begin
            send_item(ACT_FUEL, COORD_W'(c), 5'd0, 8'd255);
            send_item(ACT_FUEL, COORD_W'(c), 5'd0, 8'd255);
        end
        repeat (3) send_item(ACT_GEN, 5'd0, 5'd0, 8'd0);
        for (int r = 0; r < 4; r++)
            send_item(ACT_READ, 5'd6, COORD_W'(r), 8'd0);
        set_weights(8'd0, 8'd255, 8'd255, 8'd255);
        send_item(ACT_GEN, 5'd0, 5'd0, 8'd0);
        send_item(ACT_READ, 5'd6, 5'd2, 8'd0);
        set_weights(8'd255, 8'd0, 8'd255, 8'd0);
        send_item(ACT_FUEL, 5'd10, 5'd0, 8'd200);
        send_item(ACT_GEN, 5'd0, 5'd0, 8'd0);
        send_item(ACT_READ, 5'd10, 5'd0, 8'd0);
        send_item(ACT_READ, 5'd10, 5'd1, 8'd0);
        set_weights(8'd0, 8'd0, 8'd0, 8'd0);
        send_item(ACT_GEN, 5'd0, 5'd0, 8'd0);
        send_item(ACT_READ, 5'd10, 5'd1, 8'd0);
    endtask

    task automatic test_random_frames();
        int pick;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            set_weights(draw_weight(), draw_weight(), draw_weight(), draw_weight());
            no_idle = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    settle_block();
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    send_item(ACT_FUEL, COORD_W'($urandom_range(0, GRID_W - 1)),
                              COORD_W'($urandom_range(0, 31)),
                              FUEL_W'($urandom_range(0, 255)));
                else if (pick < 48)
                    send_item(ACT_GEN, COORD_W'($urandom_range(0, 31)),
                              COORD_W'($urandom_range(0, 31)),
                              FUEL_W'($urandom_range(0, 255)));
                else if (pick < 93)
                    send_item(ACT_READ, COORD_W'($urandom_range(0, GRID_W - 1)),
                              COORD_W'($urandom_range(0, GRID_H - 1)),
                              FUEL_W'($urandom_range(0, 255)));
                else
                    send_item(ACTION_W'($urandom_range(0, 3)),
                              COORD_W'($urandom_range(0, 31)),
                              COORD_W'($urandom_range(0, 31)),
                              FUEL_W'($urandom_range(0, 255)));
            end
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_heat_reading want;
        int hold;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_readings.size() == 0) begin
                    $error("unexpected result: temperature %0d, is_read_data %0d",
                           o_temperature, o_is_read_data);
                    errors++;
                end else begin
                    want = pending_readings.pop_front();
                    if (o_temperature !== want.temperature) begin
                        $error("temperature: expected %0d, actual %0d",
                               want.temperature, o_temperature);
                        errors++;
                    end
                    if (o_is_read_data !== want.is_read_data) begin
                        $error("is_read_data: expected %0d, actual %0d",
                               want.is_read_data, o_is_read_data);
                        errors++;
                    end
                end
                hold = no_idle ? 0 : $urandom_range(0, 10);
                stall_left = hold;
                i_out_stall <= (hold != 0);
            end else if (stall_left != 0) begin
                stall_left = stall_left - 1;
                i_out_stall <= (stall_left != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pwrite)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < GRID_CELLS; i++)
            heat_cells[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cells();
        test_weight_extremes();
        test_random_frames();
        settle_block();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending_readings.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
